[design/sske_pkg.sv]
`default_nettype none
package sske_pkg;

    localparam int INPUT_FRACTION_BITS  = 16;
    localparam int OUTPUT_FRACTION_BITS = 32;

    localparam int IN_W   = 32;
    localparam int OUT_W  = 48;
    localparam int QB     = 30;          // polynomial fraction bits
    localparam int Q_W    = 32;          // sp / sd quotient bits
    localparam int ACC_W  = 40;          // Horner accumulator
    localparam int S_W    = 42;          // S and G
    localparam int M_W    = 76;          // G*ri - S*h
    localparam int WDEN_W = 3 * IN_W;    // h*ri*rj
    localparam int GDEN_W = 5 * IN_W;    // h*h*ri*ri*rj
    localparam int SHIFT_W = 3 * INPUT_FRACTION_BITS - QB + OUTPUT_FRACTION_BITS;
    localparam int SHIFT_G = 4 * INPUT_FRACTION_BITS - QB + OUTPUT_FRACTION_BITS;
    localparam int WNUM_W = S_W + SHIFT_W;
    localparam int GNUM_W = M_W + SHIFT_G;
    localparam int QN     = OUT_W + 1;   // final quotient bits
    localparam int POLY_LEN  = 6;
    localparam int GPOLY_LEN = 5;
    localparam int HORNER_STEPS = POLY_LEN - 1;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    typedef logic signed [ACC_W-1:0] acc_t;

    localparam logic [32:0]    MAGCAP = 33'h1_FFFF_FFFF;
    localparam logic [Q_W-1:0] QCAP   = 32'h8000_0000;
    localparam logic [64:0]    HALF   = 65'd1 << (QB - 1);
    localparam logic [QN:0]    LIM_POS = (QN + 1)'((64'd1 << (OUT_W - 1)) - 64'd1);
    localparam logic [QN:0]    LIM_NEG = (QN + 1)'(64'd1 << (OUT_W - 1));

    localparam acc_t POLY_C [POLY_LEN] = '{40'sd322122547, -40'sd805306368, 40'sd0,
                                           40'sd1073741824, 40'sd0, 40'sd0};
    localparam acc_t POLY_D [POLY_LEN] = '{-40'sd107374182, 40'sd805306368,
                                           -40'sd2147483648, 40'sd2147483648,
                                           40'sd0, 40'sd0};
    localparam acc_t POLY_GC [GPOLY_LEN] = '{40'sd1610612736, -40'sd3221225472, 40'sd0,
                                             40'sd2147483648, 40'sd0};
    localparam acc_t POLY_GD [GPOLY_LEN] = '{-40'sd536870912, 40'sd3221225472,
                                             -40'sd6442450944, 40'sd4294967296, 40'sd0};
    localparam acc_t K_M01 = -40'sd107374182;
    localparam acc_t K_07  = 40'sd751619277;
    localparam acc_t K_08  = 40'sd858993459;

    typedef enum logic [2:0] {
        REG_INNER,
        REG_MID_C,
        REG_MID_D,
        REG_OUT_C,
        REG_OUT_D,
        REG_FAR
    } region_t;

    typedef struct packed {
        logic [IN_W-1:0] rj;
        logic [IN_W-1:0] ri;
        logic [IN_W-1:0] h;
        logic [IN_W:0]   sum;
        logic [IN_W-1:0] diff;
        logic            sg_neg;
        logic            use_qs;
        logic            use_qd;
        logic            fault;
        region_t         region;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        item_t           it;
        logic [IN_W-1:0] rem_s;
        logic [IN_W-1:0] rem_d;
        logic [Q_W-1:0]  quo_s;
        logic [Q_W-1:0]  quo_d;
    } qdiv_t;

    typedef struct packed {
        item_t          it;
        logic [Q_W-1:0] qs;
        logic [Q_W-1:0] qd;
        acc_t cs, ds, gcs, gds, cd, dd, gcd, gdd;
    } hor_t;

    typedef struct packed {
        logic [WDEN_W-1:0] den;
        logic [WNUM_W-1:0] num;
        logic [WDEN_W-1:0] rem;
        logic [QN-1:0]     quo;
        logic              ovf;
        logic              neg;
        logic              fault;
    } divw_t;

    typedef struct packed {
        logic [GDEN_W-1:0] den;
        logic [GNUM_W-1:0] num;
        logic [GDEN_W-1:0] rem;
        logic [QN-1:0]     quo;
        logic              ovf;
        logic              neg;
    } divg_t;

    // rounded Q30 product, multiplicand magnitude capped
    function automatic acc_t fx_mul(input acc_t a, input logic [Q_W-1:0] q);
        logic             neg;
        logic [ACC_W-1:0] m_full;
        logic [32:0]      m;
        logic [Q_W-1:0]   qc;
        logic [64:0]      p;
        logic [34:0]      r;
        neg    = a[ACC_W-1];
        m_full = neg ? -a : a;
        m      = (m_full > ACC_W'(MAGCAP)) ? MAGCAP : m_full[32:0];
        qc     = (q > QCAP) ? QCAP : q;
        p      = 65'(m) * 65'(qc) + HALF;
        r      = 35'(p >> QB);
        fx_mul = neg ? -acc_t'(r) : acc_t'(r);
    endfunction

endpackage
`default_nettype wire

[design/sske_front.sv]
`default_nettype none
module sske_front
    import sske_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [3*IN_W-1:0]    s_axis_tdata,
    input  q_stat_t              q_stat,
    output logic                 push,
    output item_t                push_item
);

    logic            fv_reg;
    item_t           item_reg;
    item_t           item_next;
    logic [IN_W-1:0] rj, ri, h;
    logic [IN_W:0]   h2;

    always_comb
    begin
        rj = s_axis_tdata[IN_W-1:0];
        ri = s_axis_tdata[2*IN_W-1:IN_W];
        h  = s_axis_tdata[3*IN_W-1:2*IN_W];
        h2 = {h, 1'b0};
        item_next.rj     = rj;
        item_next.ri     = ri;
        item_next.h      = h;
        item_next.sum    = {1'b0, rj} + {1'b0, ri};
        item_next.diff   = (ri >= rj) ? ri - rj : rj - ri;
        item_next.sg_neg = ri < rj;
        item_next.use_qs = item_next.sum <= h2;
        item_next.use_qd = {1'b0, item_next.diff} < h2;
        item_next.fault  = (h == '0) || (ri == '0) || (rj == '0);
        if (item_next.sum <= {1'b0, h})
            item_next.region = REG_INNER;
        else if (item_next.sum <= h2)
            item_next.region = (item_next.diff < h) ? REG_MID_C : REG_MID_D;
        else if (item_next.diff < h)
            item_next.region = REG_OUT_C;
        else if ({1'b0, item_next.diff} < h2)
            item_next.region = REG_OUT_D;
        else
            item_next.region = REG_FAR;
    end

    assign push          = fv_reg && !q_stat.full;
    assign s_axis_tready = !fv_reg || !q_stat.full;
    assign push_item     = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= 1'b0;
        else if (s_axis_tready)
            fv_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            item_reg <= item_next;
    end

endmodule
`default_nettype wire

[design/sske_queue.sv]
`default_nettype none
module sske_queue
    import sske_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  item_t   push_item,
    input  logic    pop,
    output item_t   head,
    output q_stat_t q_stat
);

    item_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QPTR_W:0]   cnt_reg;
    logic              do_push, do_pop;

    assign q_stat.full  = cnt_reg == (QPTR_W + 1)'(QDEPTH);
    assign q_stat.empty = cnt_reg == '0;
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= rd_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_item;
    end

endmodule
`default_nettype wire

[design/sske_back.sv]
`default_nettype none
module sske_back
    import sske_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  item_t                head,
    input  logic                 head_valid,
    output logic                 pop,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [2*OUT_W-1:0]   m_axis_tdata,
    output logic [1:0]           m_axis_tuser
);

    localparam int E0  = Q_W + HORNER_STEPS;
    localparam int D0  = E0 + 5;
    localparam int LAT = D0 + QN + 1;

    logic [LAT-1:0] v_reg;
    logic           en;

    assign en            = !v_reg[LAT-1] || m_axis_tready;
    assign pop           = en && head_valid;
    assign m_axis_tvalid = v_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[LAT-2:0], head_valid};
    end

    // sp / sd long division, one quotient bit per stage
    qdiv_t                 qa_reg [Q_W];
    qdiv_t                 qa_in;
    logic [IN_W+QB:0]      dv0_s, dv0_d;

    always_comb
    begin
        dv0_s       = {head.sum, {QB{1'b0}}};
        dv0_d       = {1'b0, head.diff, {QB{1'b0}}};
        qa_in.it    = head;
        qa_in.rem_s = IN_W'(dv0_s >> Q_W);
        qa_in.rem_d = IN_W'(dv0_d >> Q_W);
        qa_in.quo_s = '0;
        qa_in.quo_d = '0;
    end

    genvar k;
    generate
        for (k = 0; k < Q_W; k++)
        begin : g_qdiv
            qdiv_t            prev, nxt;
            logic [IN_W+QB:0] dv_s, dv_d;
            logic [IN_W:0]    ts, td;
            logic             ge_s, ge_d;
            if (k == 0)
            begin : g_first
                assign prev = qa_in;
            end
            else
            begin : g_rest
                assign prev = qa_reg[k-1];
            end
            always_comb
            begin
                dv_s      = {prev.it.sum, {QB{1'b0}}};
                dv_d      = {1'b0, prev.it.diff, {QB{1'b0}}};
                ts        = {prev.rem_s, dv_s[Q_W-1-k]};
                td        = {prev.rem_d, dv_d[Q_W-1-k]};
                ge_s      = ts >= {1'b0, prev.it.h};
                ge_d      = td >= {1'b0, prev.it.h};
                nxt.it    = prev.it;
                nxt.rem_s = ge_s ? IN_W'(ts - {1'b0, prev.it.h}) : ts[IN_W-1:0];
                nxt.rem_d = ge_d ? IN_W'(td - {1'b0, prev.it.h}) : td[IN_W-1:0];
                nxt.quo_s = {prev.quo_s[Q_W-2:0], ge_s};
                nxt.quo_d = {prev.quo_d[Q_W-2:0], ge_d};
            end
            always_ff @(posedge clk)
            begin
                if (en)
                    qa_reg[k] <= nxt;
            end
        end
    endgenerate

    // Horner, eight polynomials side by side, one product per stage (the four gradient ones hold in the last stage)
    hor_t hr_reg [HORNER_STEPS];
    hor_t hr_in;

    always_comb
    begin
        hr_in.it  = qa_reg[Q_W-1].it;
        hr_in.qs  = qa_reg[Q_W-1].it.use_qs ? qa_reg[Q_W-1].quo_s : '0;
        hr_in.qd  = qa_reg[Q_W-1].it.use_qd ? qa_reg[Q_W-1].quo_d : '0;
        hr_in.cs  = POLY_C[0];
        hr_in.cd  = POLY_C[0];
        hr_in.ds  = POLY_D[0];
        hr_in.dd  = POLY_D[0];
        hr_in.gcs = POLY_GC[0];
        hr_in.gcd = POLY_GC[0];
        hr_in.gds = POLY_GD[0];
        hr_in.gdd = POLY_GD[0];
    end

    generate
        for (k = 0; k < HORNER_STEPS; k++)
        begin : g_horner
            hor_t prev, nxt;
            acc_t gcs_n, gds_n, gcd_n, gdd_n;
            if (k == 0)
            begin : g_first
                assign prev = hr_in;
            end
            else
            begin : g_rest
                assign prev = hr_reg[k-1];
            end
            if (k < GPOLY_LEN - 1)
            begin : g_gstep
                assign gcs_n = fx_mul(prev.gcs, prev.qs) + POLY_GC[k+1];
                assign gds_n = fx_mul(prev.gds, prev.qs) + POLY_GD[k+1];
                assign gcd_n = fx_mul(prev.gcd, prev.qd) + POLY_GC[k+1];
                assign gdd_n = fx_mul(prev.gdd, prev.qd) + POLY_GD[k+1];
            end
            else
            begin : g_ghold
                assign gcs_n = prev.gcs;
                assign gds_n = prev.gds;
                assign gcd_n = prev.gcd;
                assign gdd_n = prev.gdd;
            end
            always_comb
            begin
                nxt     = prev;
                nxt.cs  = fx_mul(prev.cs, prev.qs) + POLY_C[k+1];
                nxt.ds  = fx_mul(prev.ds, prev.qs) + POLY_D[k+1];
                nxt.cd  = fx_mul(prev.cd, prev.qd) + POLY_C[k+1];
                nxt.dd  = fx_mul(prev.dd, prev.qd) + POLY_D[k+1];
                nxt.gcs = gcs_n;
                nxt.gds = gds_n;
                nxt.gcd = gcd_n;
                nxt.gdd = gdd_n;
            end
            always_ff @(posedge clk)
            begin
                if (en)
                    hr_reg[k] <= nxt;
            end
        end
    endgenerate

    // E1: region select, h*ri
    hor_t                    hl;
    acc_t                    sgcd, sgdd;
    logic signed [S_W-1:0]   s_next, g_next;
    logic signed [S_W-1:0]   e1_s_reg, e1_g_reg;
    logic [2*IN_W-1:0]       e1_x_reg;
    logic [IN_W-1:0]         e1_ri_reg, e1_rj_reg, e1_h_reg;
    logic                    e1_f_reg;

    assign hl = hr_reg[HORNER_STEPS-1];

    always_comb
    begin
        sgcd = hl.it.sg_neg ? -hl.gcd : hl.gcd;
        sgdd = hl.it.sg_neg ? -hl.gdd : hl.gdd;
        case (hl.it.region)
            REG_INNER:
            begin
                s_next = S_W'(hl.cs) - S_W'(hl.cd);
                g_next = S_W'(hl.gcs) - S_W'(sgcd);
            end
            REG_MID_C:
            begin
                s_next = S_W'(K_M01) + S_W'(hl.ds) - S_W'(hl.cd);
                g_next = S_W'(hl.gds) - S_W'(sgcd);
            end
            REG_MID_D:
            begin
                s_next = S_W'(hl.ds) - S_W'(hl.dd);
                g_next = S_W'(hl.gds) - S_W'(sgdd);
            end
            REG_OUT_C:
            begin
                s_next = S_W'(K_07) - S_W'(hl.cd);
                g_next = -S_W'(sgcd);
            end
            REG_OUT_D:
            begin
                s_next = S_W'(K_08) - S_W'(hl.dd);
                g_next = -S_W'(sgdd);
            end
            default:
            begin
                s_next = '0;
                g_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_s_reg  <= s_next;
            e1_g_reg  <= g_next;
            e1_x_reg  <= hl.it.h * hl.it.ri;
            e1_ri_reg <= hl.it.ri;
            e1_rj_reg <= hl.it.rj;
            e1_h_reg  <= hl.it.h;
            e1_f_reg  <= hl.it.fault;
        end
    end

    // E2: G*ri, S*h split into low and high halves, h*ri*rj partials
    logic signed [S_W:0]   e2_pgh_reg, e2_psh_reg;
    logic [2*IN_W-1:0]     e2_pgl_reg, e2_psl_reg;
    logic [2*IN_W-1:0]     e2_wl_reg, e2_wh_reg, e2_x_reg;
    logic signed [S_W-1:0] e2_s_reg;
    logic                  e2_f_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e2_pgh_reg <= $signed(e1_g_reg[S_W-1:IN_W]) * $signed({1'b0, e1_ri_reg});
            e2_pgl_reg <= e1_g_reg[IN_W-1:0] * e1_ri_reg;
            e2_psh_reg <= $signed(e1_s_reg[S_W-1:IN_W]) * $signed({1'b0, e1_h_reg});
            e2_psl_reg <= e1_s_reg[IN_W-1:0] * e1_h_reg;
            e2_wl_reg  <= e1_x_reg[IN_W-1:0] * e1_rj_reg;
            e2_wh_reg  <= e1_x_reg[2*IN_W-1:IN_W] * e1_rj_reg;
            e2_x_reg   <= e1_x_reg;
            e2_s_reg   <= e1_s_reg;
            e2_f_reg   <= e1_f_reg;
        end
    end

    // E3: M and h*ri*rj
    logic signed [M_W-1:0] e3_m_reg;
    logic [WDEN_W-1:0]     e3_wden_reg;
    logic [2*IN_W-1:0]     e3_x_reg;
    logic signed [S_W-1:0] e3_s_reg;
    logic                  e3_f_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e3_m_reg    <= (M_W'(e2_pgh_reg) << IN_W) + M_W'(e2_pgl_reg)
                           - (M_W'(e2_psh_reg) << IN_W) - M_W'(e2_psl_reg);
            e3_wden_reg <= WDEN_W'(e2_wl_reg) + {e2_wh_reg, {IN_W{1'b0}}};
            e3_x_reg    <= e2_x_reg;
            e3_s_reg    <= e2_s_reg;
            e3_f_reg    <= e2_f_reg;
        end
    end

    // E4: partials of (h*ri) * (h*ri*rj)
    logic [2*IN_W-1:0]     e4_pp_reg [2][3];
    logic [WDEN_W-1:0]     e4_wden_reg;
    logic signed [M_W-1:0] e4_m_reg;
    logic signed [S_W-1:0] e4_s_reg;
    logic                  e4_f_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 2; i++)
                for (int j = 0; j < 3; j++)
                    e4_pp_reg[i][j] <= e3_x_reg[i*IN_W +: IN_W] * e3_wden_reg[j*IN_W +: IN_W];
            e4_wden_reg <= e3_wden_reg;
            e4_m_reg    <= e3_m_reg;
            e4_s_reg    <= e3_s_reg;
            e4_f_reg    <= e3_f_reg;
        end
    end

    // E5: gradient denominator, magnitudes
    logic [GDEN_W-1:0] gden_next;
    logic [GDEN_W-1:0] e5_gden_reg;
    logic [WDEN_W-1:0] e5_wden_reg;
    logic [S_W-1:0]    e5_smag_reg;
    logic [M_W-1:0]    e5_mmag_reg;
    logic              e5_sneg_reg, e5_mneg_reg, e5_f_reg;

    always_comb
    begin
        gden_next = '0;
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 3; j++)
                gden_next = gden_next + (GDEN_W'(e4_pp_reg[i][j]) << (IN_W * (i + j)));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e5_gden_reg <= gden_next;
            e5_wden_reg <= e4_wden_reg;
            e5_smag_reg <= e4_s_reg[S_W-1] ? S_W'(-e4_s_reg) : S_W'(e4_s_reg);
            e5_mmag_reg <= e4_m_reg[M_W-1] ? M_W'(-e4_m_reg) : M_W'(e4_m_reg);
            e5_sneg_reg <= e4_s_reg[S_W-1];
            e5_mneg_reg <= e4_m_reg[M_W-1];
            e5_f_reg    <= e4_f_reg;
        end
    end

    // final rounded divisions, one quotient bit per stage
    divw_t dw_reg [QN];
    divg_t dg_reg [QN];
    divw_t dw_in;
    divg_t dg_in;

    always_comb
    begin
        dw_in.den   = e5_wden_reg;
        dw_in.num   = {e5_smag_reg, {SHIFT_W{1'b0}}};
        dw_in.rem   = WDEN_W'(dw_in.num >> QN);
        dw_in.ovf   = dw_in.rem >= dw_in.den;
        dw_in.quo   = '0;
        dw_in.neg   = e5_sneg_reg;
        dw_in.fault = e5_f_reg;
        dg_in.den   = e5_gden_reg;
        dg_in.num   = {e5_mmag_reg, {SHIFT_G{1'b0}}};
        dg_in.rem   = GDEN_W'(dg_in.num >> QN);
        dg_in.ovf   = dg_in.rem >= dg_in.den;
        dg_in.quo   = '0;
        dg_in.neg   = e5_mneg_reg;
    end

    generate
        for (k = 0; k < QN; k++)
        begin : g_div
            divw_t           pw, nw;
            divg_t           pg, ng;
            logic [WDEN_W:0] tw;
            logic [GDEN_W:0] tg;
            logic            gew, geg;
            if (k == 0)
            begin : g_first
                assign pw = dw_in;
                assign pg = dg_in;
            end
            else
            begin : g_rest
                assign pw = dw_reg[k-1];
                assign pg = dg_reg[k-1];
            end
            always_comb
            begin
                tw     = {pw.rem, pw.num[QN-1-k]};
                tg     = {pg.rem, pg.num[QN-1-k]};
                gew    = tw >= {1'b0, pw.den};
                geg    = tg >= {1'b0, pg.den};
                nw     = pw;
                ng     = pg;
                nw.rem = gew ? WDEN_W'(tw - {1'b0, pw.den}) : tw[WDEN_W-1:0];
                ng.rem = geg ? GDEN_W'(tg - {1'b0, pg.den}) : tg[GDEN_W-1:0];
                nw.quo = {pw.quo[QN-2:0], gew};
                ng.quo = {pg.quo[QN-2:0], geg};
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dw_reg[k] <= nw;
                    dg_reg[k] <= ng;
                end
            end
        end
    endgenerate

    // round, saturate, output register
    divw_t              fw;
    divg_t              fg;
    logic [QN:0]        qrw, qrg, limw, limg, magw, magg;
    logic               satw, satg;
    logic [OUT_W-1:0]   val_w, val_g;
    logic [OUT_W-1:0]   out_w_reg, out_g_reg;
    logic               out_f_reg, out_s_reg;

    assign fw = dw_reg[QN-1];
    assign fg = dg_reg[QN-1];

    always_comb
    begin
        qrw   = (QN + 1)'(fw.quo) + (QN + 1)'({fw.rem, 1'b0} >= {1'b0, fw.den});
        qrg   = (QN + 1)'(fg.quo) + (QN + 1)'({fg.rem, 1'b0} >= {1'b0, fg.den});
        limw  = fw.neg ? LIM_NEG : LIM_POS;
        limg  = fg.neg ? LIM_NEG : LIM_POS;
        satw  = fw.ovf || (qrw > limw);
        satg  = fg.ovf || (qrg > limg);
        magw  = satw ? limw : qrw;
        magg  = satg ? limg : qrg;
        val_w = fw.neg ? -OUT_W'(magw) : OUT_W'(magw);
        val_g = fg.neg ? -OUT_W'(magg) : OUT_W'(magg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_w_reg <= fw.fault ? '0 : val_w;
            out_g_reg <= fw.fault ? '0 : val_g;
            out_f_reg <= fw.fault;
            out_s_reg <= !fw.fault && (satw || satg);
        end
    end

    assign m_axis_tdata = {out_g_reg, out_w_reg};
    assign m_axis_tuser = {out_s_reg, out_f_reg};

endmodule
`default_nettype wire

[design/spherical_sph_kernel_eval_top.sv]
`default_nettype none
// Spherical SPH cubic B-spline kernel evaluator. One input beat carries a
// particle pair (rj, ri, h; unsigned Q16.16) and yields one output beat with
// the kernel W = S/(h*ri*rj) and its radial gradient dW/dri, both signed Q16.32,
// rounded to nearest and clipped to the 48-bit range. The block takes one beat
// every cycle while the output is not stalled: every divider and polynomial
// step is a pipeline stage, so the rate is one pair per clock. The path from
// input beat to output beat runs through one classify register, the 4-entry
// queue, 32 stages for the sp/sd quotients, 5 Horner stages, 5 product/combine
// stages, 49 stages of the final restoring dividers and the output register.
// When the output side stalls the back pipeline holds and the queue absorbs
// input until full. A zero h, ri or rj sets divide_fault with zero outputs.
module spherical_sph_kernel_eval_top
    import sske_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [3*IN_W-1:0]    s_axis_tdata,   // radius_j, radius_i, smoothing_length
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [2*OUT_W-1:0]   m_axis_tdata,   // kernel_value, kernel_gradient
    output logic [1:0]           m_axis_tuser    // divide_fault, saturated
);

    q_stat_t q_stat;
    logic    push, pop;
    item_t   push_item, head;

    // front: capture beat, region compares, fault detect
    sske_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_stat        (q_stat),
        .push          (push),
        .push_item     (push_item)
    );

    // queue decouples front from the stallable back pipeline
    sske_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    // back: dividers, polynomials, final quotients
    sske_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_valid    (!q_stat.empty),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
`default_nettype wire
